[src/tts_pkg.sv]
// Shared types, character codes and defaults for the text token scanner.
package tts_pkg;

  // Default configuration of the top level.
  localparam int MAX_LEXEME_LEN_DEF = 32;
  localparam int LINE_BITS_DEF      = 16;

  // Fixed field widths of the result channel.
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 4;
  localparam int INDEX_W = 5;
  localparam int LINE_W  = 16;

  // Characters that steer the scanner.
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z  = 8'h7A;

  // Token kinds as they appear on the result channel.
  typedef enum logic [KIND_W-1:0] {
    K_END      = 4'd0,
    K_EQUAL    = 4'd1,
    K_COLON    = 4'd2,
    K_COMMA    = 4'd3,
    K_QUESTION = 4'd4,
    K_MINUS    = 4'd5,
    K_PLUS     = 4'd6,
    K_INTEGER  = 4'd7,
    K_REAL     = 4'd8,
    K_DATE     = 4'd9,
    K_IDENT    = 4'd10,
    K_STRING   = 4'd11,
    K_ERROR    = 4'd12
  } kind_t;

  // Token being collected between bytes.
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_MINUS = 4'd1,
    M_PLUS  = 4'd2,
    M_INT   = 4'd3,
    M_REAL  = 4'd4,
    M_DATE1 = 4'd5,
    M_DATE2 = 4'd6,
    M_NUMID = 4'd7,
    M_IDENT = 4'd8,
    M_STR   = 4'd9,
    M_STRQ  = 4'd10
  } mode_t;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    ST_SCAN,
    ST_EMIT,
    ST_RESCAN
  } top_state_t;

  // Replay unit states.
  typedef enum logic [1:0] {
    R_IDLE,
    R_READ,
    R_LOAD
  } replay_state_t;

  // Control decisions of one scan step.
  typedef struct packed {
    mode_t mode_nxt;
    logic  wr_en;
    logic  ovf_nxt;
    logic  line_inc;
    logic  emit;
    kind_t kind;
    logic  rescan;
  } scan_ctl_t;

  // Token description handed to the replay unit.
  typedef struct packed {
    kind_t             kind;
    logic              ovf;
    logic [LINE_W-1:0] line;
  } token_info_t;

endpackage

[src/tts_lexeme_ram.sv]
// Lexeme buffer: one write port and one registered read port.
module tts_lexeme_ram
  import tts_pkg::*;
#(
  parameter int DEPTH = MAX_LEXEME_LEN_DEF,
  parameter int AW    = $clog2(MAX_LEXEME_LEN_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/tts_classify.sv]
// One scan step: classifies a byte against the pending token and decides writes and emission.
module tts_classify
  import tts_pkg::*;
#(
  parameter int MAX_LEXEME_LEN = MAX_LEXEME_LEN_DEF,
  parameter int LEN_W          = $clog2(MAX_LEXEME_LEN_DEF + 1),
  parameter int AW             = $clog2(MAX_LEXEME_LEN_DEF)
) (
  input  mode_t             mode,
  input  logic [BYTE_W-1:0] scan_byte,
  input  logic [LEN_W-1:0]  len,
  input  logic              ovf,
  output scan_ctl_t         ctl,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic [LEN_W-1:0]  len_nxt
);

  logic is_digit;
  logic is_alpha;
  logic is_space;
  logic can_add;
  logic add_req;
  logic start_req;
  logic clear_req;

  // Character classes.
  assign is_digit = (scan_byte >= CH_ZERO) && (scan_byte <= CH_NINE);
  assign is_alpha = ((scan_byte >= CH_UP_A) && (scan_byte <= CH_UP_Z)) ||
                    ((scan_byte >= CH_LOW_A) && (scan_byte <= CH_LOW_Z));
  assign is_space = (scan_byte == CH_SPACE) ||
                    ((scan_byte >= CH_TAB) && (scan_byte <= CH_CR));
  assign can_add  = len < LEN_W'(MAX_LEXEME_LEN);

  // Token state machine for one byte.
  always_comb begin
    ctl          = '0;
    ctl.mode_nxt = mode;
    ctl.ovf_nxt  = ovf;
    ctl.kind     = K_END;
    add_req      = 1'b0;
    start_req    = 1'b0;
    clear_req    = 1'b0;
    wr_data      = scan_byte;

    case (mode)
      M_MINUS: begin
        if (is_digit) begin
          add_req      = 1'b1;
          ctl.mode_nxt = M_INT;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_MINUS;
          ctl.rescan = 1'b1;
        end
      end
      M_PLUS: begin
        if (is_digit) begin
          add_req      = 1'b1;
          ctl.mode_nxt = M_INT;
        end else begin
          // A lone plus sign is sent with its own character as lexeme.
          start_req  = 1'b1;
          wr_data    = CH_PLUS;
          ctl.emit   = 1'b1;
          ctl.kind   = K_PLUS;
          ctl.rescan = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit) begin
          add_req = 1'b1;
        end else if (scan_byte == CH_DOT) begin
          add_req      = 1'b1;
          ctl.mode_nxt = M_REAL;
        end else if (scan_byte == CH_SLASH) begin
          add_req      = 1'b1;
          ctl.mode_nxt = M_DATE1;
        end else if (is_alpha) begin
          add_req      = 1'b1;
          ctl.mode_nxt = M_NUMID;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_INTEGER;
          ctl.rescan = 1'b1;
        end
      end
      M_REAL: begin
        if (is_digit) begin
          add_req = 1'b1;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_REAL;
          ctl.rescan = 1'b1;
        end
      end
      M_DATE1: begin
        if (is_digit) begin
          add_req = 1'b1;
        end else if (scan_byte == CH_SLASH) begin
          add_req      = 1'b1;
          ctl.mode_nxt = M_DATE2;
        end else begin
          // Only one slash seen: the date is broken.
          ctl.emit   = 1'b1;
          ctl.kind   = K_ERROR;
          ctl.rescan = 1'b1;
        end
      end
      M_DATE2: begin
        if (is_digit) begin
          add_req = 1'b1;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_DATE;
          ctl.rescan = 1'b1;
        end
      end
      M_NUMID: begin
        if (is_alpha) begin
          add_req = 1'b1;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_IDENT;
          ctl.rescan = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha || is_digit || (scan_byte == CH_UNDER)) begin
          add_req = 1'b1;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_IDENT;
          ctl.rescan = 1'b1;
        end
      end
      M_STR: begin
        if (scan_byte == CH_NUL) begin
          // End of text inside a string.
          ctl.emit   = 1'b1;
          ctl.kind   = K_ERROR;
          ctl.rescan = 1'b1;
        end else if (scan_byte == CH_QUOTE) begin
          ctl.mode_nxt = M_STRQ;
        end else begin
          add_req = 1'b1;
        end
      end
      M_STRQ: begin
        if (scan_byte == CH_QUOTE) begin
          // A doubled quote stands for one quote character.
          add_req      = 1'b1;
          ctl.mode_nxt = M_STR;
        end else begin
          ctl.emit   = 1'b1;
          ctl.kind   = K_STRING;
          ctl.rescan = 1'b1;
        end
      end
      default: begin
        // Idle, and any unused code, takes the byte as the start of a token.
        if (is_space) begin
          ctl.line_inc = (scan_byte == CH_NL);
        end else if (scan_byte == CH_NUL) begin
          clear_req = 1'b1;
          ctl.emit  = 1'b1;
          ctl.kind  = K_END;
        end else if (scan_byte == CH_EQUAL) begin
          start_req = 1'b1;
          ctl.emit  = 1'b1;
          ctl.kind  = K_EQUAL;
        end else if (scan_byte == CH_COLON) begin
          start_req = 1'b1;
          ctl.emit  = 1'b1;
          ctl.kind  = K_COLON;
        end else if (scan_byte == CH_COMMA) begin
          start_req = 1'b1;
          ctl.emit  = 1'b1;
          ctl.kind  = K_COMMA;
        end else if (scan_byte == CH_QUEST) begin
          start_req = 1'b1;
          ctl.emit  = 1'b1;
          ctl.kind  = K_QUESTION;
        end else if (scan_byte == CH_MINUS) begin
          start_req    = 1'b1;
          ctl.mode_nxt = M_MINUS;
        end else if (scan_byte == CH_PLUS) begin
          clear_req    = 1'b1;
          ctl.mode_nxt = M_PLUS;
        end else if (is_digit) begin
          start_req    = 1'b1;
          ctl.mode_nxt = M_INT;
        end else if (is_alpha) begin
          start_req    = 1'b1;
          ctl.mode_nxt = M_IDENT;
        end else if (scan_byte == CH_QUOTE) begin
          clear_req    = 1'b1;
          ctl.mode_nxt = M_STR;
        end else begin
          // Stray byte: an error token of that one byte.
          start_req = 1'b1;
          ctl.emit  = 1'b1;
          ctl.kind  = K_ERROR;
        end
      end
    endcase

    // Buffer and length updates.
    wr_addr = len[AW-1:0];
    len_nxt = len;
    if (start_req) begin
      ctl.wr_en   = 1'b1;
      wr_addr     = '0;
      len_nxt     = LEN_W'(1);
      ctl.ovf_nxt = 1'b0;
    end else if (clear_req) begin
      len_nxt     = '0;
      ctl.ovf_nxt = 1'b0;
    end else if (add_req) begin
      if (can_add) begin
        ctl.wr_en = 1'b1;
        len_nxt   = len + LEN_W'(1);
      end else begin
        ctl.ovf_nxt = 1'b1;
      end
    end

    if (ctl.emit) begin
      ctl.mode_nxt = M_IDLE;
    end
  end

endmodule

[src/tts_replay.sv]
// Replays a finished lexeme from the buffer, one result per byte, through the output register.
module tts_replay
  import tts_pkg::*;
#(
  parameter int LEN_W = $clog2(MAX_LEXEME_LEN_DEF + 1),
  parameter int AW    = $clog2(MAX_LEXEME_LEN_DEF)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  token_info_t        info,
  input  logic [LEN_W-1:0]   cnt,
  output logic               busy,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [BYTE_W-1:0]  rd_data,
  input  logic               res_stall,
  output logic               res_valid,
  output logic [KIND_W-1:0]  res_kind,
  output logic [BYTE_W-1:0]  res_byte,
  output logic               res_byte_valid,
  output logic [INDEX_W-1:0] res_index,
  output logic               res_last,
  output logic [LINE_W-1:0]  res_line,
  output logic               res_ovf
);

  replay_state_t      state_r, state_nxt;
  token_info_t        info_r, info_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;

  logic               valid_r, valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic               last_r, last_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               ovf_r, ovf_nxt;

  logic               empty;
  logic               is_last;
  logic               out_free;
  logic [31:0]        idx_ext;

  assign empty    = (cnt_r == '0);
  assign is_last  = empty || ((LEN_W'(idx_r) + LEN_W'(1)) == cnt_r);
  assign out_free = !valid_r || !res_stall;
  assign idx_ext  = 32'(idx_r);
  assign busy     = (state_r != R_IDLE);

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    info_r   <= info_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    index_r  <= index_nxt;
    last_r   <= last_nxt;
    line_r   <= line_nxt;
    ovf_r    <= ovf_nxt;
  end

  // Read sequencing and output register loading.
  always_comb begin
    state_nxt  = state_r;
    info_nxt   = info_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    valid_nxt  = valid_r && res_stall;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    bvalid_nxt = bvalid_r;
    index_nxt  = index_r;
    last_nxt   = last_r;
    line_nxt   = line_r;
    ovf_nxt    = ovf_r;

    case (state_r)
      R_IDLE: begin
        if (start) begin
          info_nxt  = info;
          cnt_nxt   = cnt;
          idx_nxt   = '0;
          // An empty lexeme needs no read.
          state_nxt = (cnt == '0) ? R_LOAD : R_READ;
        end
      end
      R_READ: begin
        rd_en     = 1'b1;
        state_nxt = R_LOAD;
      end
      R_LOAD: begin
        if (out_free) begin
          valid_nxt  = 1'b1;
          kind_nxt   = info_r.kind;
          byte_nxt   = empty ? '0 : rd_data;
          bvalid_nxt = !empty;
          index_nxt  = idx_ext[INDEX_W-1:0];
          last_nxt   = is_last;
          line_nxt   = info_r.line;
          ovf_nxt    = info_r.ovf;
          if (is_last) begin
            state_nxt = R_IDLE;
          end else begin
            // Fetch the next byte while this one is shown.
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  assign res_valid      = valid_r;
  assign res_kind       = kind_r;
  assign res_byte       = byte_r;
  assign res_byte_valid = bvalid_r;
  assign res_index      = index_r;
  assign res_last       = last_r;
  assign res_line       = line_r;
  assign res_ovf        = ovf_r;

endmodule

[src/text_token_scanner_top.sv]
// Top level of the text token scanner: scan state, sequencer and lexeme buffer.
//
// Usage: text arrives one byte per request on the in_ channel (zero ends a text).
// Each finished token leaves on the out_ channel as its lexeme bytes, one request
// per byte, with out_last_of_token on the final one; an empty lexeme (such as an end
// token or an empty string) gives one request with out_byte_valid low.
// Throughput: a byte that does not finish a token is taken without holding the input.
// A byte that finishes a token holds the input for the replay of that token: setup,
// buffer read and handback, then one result per lexeme byte, then a second scan of
// the byte when it must be scanned again after the token (and more when the byte
// scanned again finishes a token of its own).
// The replay reads the lexeme buffer through its single registered read port,
// and that port sets the one byte per cycle on the output side while out_stall is low.
// Latency: after the byte that finishes a token is taken, the replay reads the buffer
// (no read for an empty lexeme), then loads the first result into the output register.
// Reset: rst_n is synchronous; afterwards no token is pending and the line count
// is one. The lexeme buffer is not cleared.
// Stall: a result waits in the output register while out_stall is high, and the
// replay, and with it the input, waits behind it until the last result is loaded.
module text_token_scanner_top
  import tts_pkg::*;
#(
  parameter int MAX_LEXEME_LEN = MAX_LEXEME_LEN_DEF,
  parameter int LINE_BITS      = LINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_text_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_token_kind,
  output logic [BYTE_W-1:0]  out_lexeme_byte,
  output logic               out_byte_valid,
  output logic [INDEX_W-1:0] out_byte_index,
  output logic               out_last_of_token,
  output logic [LINE_W-1:0]  out_line_number,
  output logic               out_lexeme_overflow
);

  localparam int LEN_W = $clog2(MAX_LEXEME_LEN + 1);
  localparam int AW    = $clog2(MAX_LEXEME_LEN);

  top_state_t           state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic                 rescan_r, rescan_nxt;

  scan_ctl_t            ctl;
  logic [AW-1:0]        wr_addr;
  logic [BYTE_W-1:0]    wr_data;
  logic [LEN_W-1:0]     step_len;
  logic [BYTE_W-1:0]    scan_byte;
  logic                 step_en;
  logic                 start;
  logic                 busy;
  token_info_t          info;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [BYTE_W-1:0]    rd_data;
  logic [31:0]          line_ext;

  // Byte under scan: the held byte when it is scanned again after a token.
  assign scan_byte = (state_r == ST_RESCAN) ? byte_r : in_text_byte;

  tts_classify #(
    .MAX_LEXEME_LEN (MAX_LEXEME_LEN),
    .LEN_W          (LEN_W),
    .AW             (AW)
  ) u_classify (
    .mode      (mode_r),
    .scan_byte (scan_byte),
    .len       (len_r),
    .ovf       (ovf_r),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .len_nxt   (step_len)
  );

  tts_lexeme_ram #(
    .DEPTH (MAX_LEXEME_LEN),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (step_en && ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Line shown with a token saturates at the width of the line field.
  assign line_ext  = 32'(line_r);
  assign info.kind = ctl.kind;
  assign info.ovf  = ctl.ovf_nxt;
  assign info.line = (line_ext > 32'h0000_FFFF) ? 16'hFFFF : line_ext[LINE_W-1:0];

  tts_replay #(
    .LEN_W (LEN_W),
    .AW    (AW)
  ) u_replay (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .info           (info),
    .cnt            (step_len),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .res_stall      (out_stall),
    .res_valid      (out_valid),
    .res_kind       (out_token_kind),
    .res_byte       (out_lexeme_byte),
    .res_byte_valid (out_byte_valid),
    .res_index      (out_byte_index),
    .res_last       (out_last_of_token),
    .res_line       (out_line_number),
    .res_ovf        (out_lexeme_overflow)
  );

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SCAN;
      mode_r   <= M_IDLE;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      line_r   <= LINE_BITS'(1);
      rescan_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      line_r   <= line_nxt;
      rescan_r <= rescan_nxt;
    end
    byte_r <= byte_nxt;
  end

  // Sequencer: scan a byte, replay a finished token, then scan the byte again if needed.
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    line_nxt   = line_r;
    rescan_nxt = rescan_r;
    byte_nxt   = byte_r;
    in_stall   = 1'b1;
    step_en    = 1'b0;

    case (state_r)
      ST_SCAN: begin
        in_stall = 1'b0;
        step_en  = in_valid;
        if (in_valid) begin
          byte_nxt   = in_text_byte;
          rescan_nxt = ctl.rescan;
        end
      end
      ST_RESCAN: begin
        step_en    = 1'b1;
        rescan_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end
      ST_EMIT: begin
        if (!busy) begin
          state_nxt = rescan_r ? ST_RESCAN : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_SCAN;
      end
    endcase

    if (step_en) begin
      mode_nxt = ctl.mode_nxt;
      len_nxt  = step_len;
      ovf_nxt  = ctl.ovf_nxt;
      if (ctl.line_inc && (line_r != '1)) begin
        line_nxt = line_r + LINE_BITS'(1);
      end
      if (ctl.emit) begin
        state_nxt = ST_EMIT;
      end
    end
  end

  assign start = step_en && ctl.emit;

endmodule

[test/tb.sv]
// Self-checking testbench for the text token scanner top level.
`timescale 1ns / 100ps

module tb;
  import tts_pkg::*;

  typedef logic [BYTE_W-1:0] char_t;

  // One result request as the scanner should send it.
  typedef struct packed {
    kind_t              kind;
    char_t              lex;
    logic               bvalid;
    logic [INDEX_W-1:0] idx;
    logic               fin;
    logic [LINE_W-1:0]  line;
    logic               ovf;
  } lexeme_beat_t;

  // Shapes of text that the random part builds.
  typedef enum int {
    SH_INT, SH_REAL, SH_DATE, SH_BROKEN_DATE, SH_IDENT, SH_NUMID,
    SH_STRING, SH_OPEN_STRING, SH_PUNCT, SH_SPACE, SH_END, SH_NOISE
  } shape_t;

  localparam int    LEX_MAX     = MAX_LEXEME_LEN_DEF;
  localparam int    LINE_TOP    = (1 << LINE_BITS_DEF) - 1;
  localparam int    CYCLE_LIMIT = 600_000;
  localparam string PUNCT       = "=:,?-+";

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_text_byte;
  logic               out_valid;
  logic               out_stall;
  logic [KIND_W-1:0]  out_token_kind;
  logic [BYTE_W-1:0]  out_lexeme_byte;
  logic               out_byte_valid;
  logic [INDEX_W-1:0] out_byte_index;
  logic               out_last_of_token;
  logic [LINE_W-1:0]  out_line_number;
  logic               out_lexeme_overflow;

  text_token_scanner_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_lexeme_byte    (out_lexeme_byte),
    .out_byte_valid     (out_byte_valid),
    .out_byte_index     (out_byte_index),
    .out_last_of_token  (out_last_of_token),
    .out_line_number    (out_line_number),
    .out_lexeme_overflow(out_lexeme_overflow)
  );

  // Scanner state as the testbench tracks it.
  mode_t        scan_st;
  char_t        lex_buf [LEX_MAX];
  int           lex_len;
  int           line_cnt;
  logic         lex_ovf;
  lexeme_beat_t lex_beats [$];

  int src_idle_pct;
  int sink_stall_pct;
  int n_bytes;
  int n_live_bytes;
  int n_checked;
  int n_tokens;
  int n_overflows;
  int n_errors;
  int cycle_cnt;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random, changed on the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, lex_beats.size());
      $display("tb failed");
      $finish;
    end
  end

  // Character classes.
  function automatic bit digit_ch(char_t c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit alpha_ch(char_t c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
  endfunction

  function automatic bit space_ch(char_t c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Appends one byte to the lexeme, or flags it as dropped once full.
  function automatic void lex_push(char_t c);
    if (lex_len < LEX_MAX) begin
      lex_buf[lex_len] = c;
      lex_len++;
    end else begin
      lex_ovf = 1'b1;
    end
  endfunction

  function automatic void lex_restart();
    lex_len = 0;
    lex_ovf = 1'b0;
  endfunction

  // Queues the results of one finished token; an empty lexeme gives one result.
  function automatic void emit_token(kind_t k);
    lexeme_beat_t beat;
    int cnt;
    cnt = (lex_len == 0) ? 1 : lex_len;
    for (int i = 0; i < cnt; i++) begin
      beat.kind   = k;
      beat.bvalid = (lex_len != 0);
      beat.lex    = beat.bvalid ? lex_buf[i] : CH_NUL;
      beat.idx    = INDEX_W'(i);
      beat.fin    = (i == cnt - 1);
      beat.line   = LINE_W'((line_cnt > LINE_TOP) ? LINE_TOP : line_cnt);
      beat.ovf    = lex_ovf;
      lex_beats.push_back(beat);
    end
    scan_st = M_IDLE;
  endfunction

  function automatic void emit_single(kind_t k, char_t c);
    lex_restart();
    lex_push(c);
    emit_token(k);
  endfunction

  // A byte seen with no token pending.
  function automatic void scan_fresh(char_t c);
    if (space_ch(c)) begin
      if (c == CH_NL && line_cnt < LINE_TOP) line_cnt++;
    end else if (c == CH_NUL) begin
      lex_restart();
      emit_token(K_END);
    end else if (c == CH_EQUAL) begin
      emit_single(K_EQUAL, c);
    end else if (c == CH_COLON) begin
      emit_single(K_COLON, c);
    end else if (c == CH_COMMA) begin
      emit_single(K_COMMA, c);
    end else if (c == CH_QUEST) begin
      emit_single(K_QUESTION, c);
    end else if (c == CH_MINUS) begin
      lex_restart();
      lex_push(c);
      scan_st = M_MINUS;
    end else if (c == CH_PLUS) begin
      lex_restart();
      scan_st = M_PLUS;
    end else if (digit_ch(c)) begin
      lex_restart();
      lex_push(c);
      scan_st = M_INT;
    end else if (alpha_ch(c)) begin
      lex_restart();
      lex_push(c);
      scan_st = M_IDENT;
    end else if (c == CH_QUOTE) begin
      lex_restart();
      scan_st = M_STR;
    end else begin
      emit_single(K_ERROR, c);
    end
  endfunction

  // A byte offered to the pending token; returns 1 when it must be scanned again.
  function automatic bit feed_pending(char_t c);
    case (scan_st)
      M_MINUS, M_PLUS: begin
        if (digit_ch(c)) begin
          lex_push(c);
          scan_st = M_INT;
          return 1'b0;
        end
        if (scan_st == M_MINUS) emit_token(K_MINUS);
        else emit_single(K_PLUS, CH_PLUS);
        return 1'b1;
      end
      M_INT: begin
        if (digit_ch(c)) begin
          lex_push(c);
          return 1'b0;
        end
        if (c == CH_DOT || c == CH_SLASH || alpha_ch(c)) begin
          lex_push(c);
          scan_st = (c == CH_DOT) ? M_REAL : (c == CH_SLASH) ? M_DATE1 : M_NUMID;
          return 1'b0;
        end
        emit_token(K_INTEGER);
        return 1'b1;
      end
      M_REAL: begin
        if (digit_ch(c)) begin
          lex_push(c);
          return 1'b0;
        end
        emit_token(K_REAL);
        return 1'b1;
      end
      M_DATE1: begin
        if (digit_ch(c) || c == CH_SLASH) begin
          lex_push(c);
          if (c == CH_SLASH) scan_st = M_DATE2;
          return 1'b0;
        end
        emit_token(K_ERROR);
        return 1'b1;
      end
      M_DATE2: begin
        if (digit_ch(c)) begin
          lex_push(c);
          return 1'b0;
        end
        emit_token(K_DATE);
        return 1'b1;
      end
      M_NUMID: begin
        if (alpha_ch(c)) begin
          lex_push(c);
          return 1'b0;
        end
        emit_token(K_IDENT);
        return 1'b1;
      end
      M_IDENT: begin
        if (alpha_ch(c) || digit_ch(c) || c == CH_UNDER) begin
          lex_push(c);
          return 1'b0;
        end
        emit_token(K_IDENT);
        return 1'b1;
      end
      M_STR: begin
        if (c == CH_NUL) begin
          emit_token(K_ERROR);
          return 1'b1;
        end
        if (c == CH_QUOTE) scan_st = M_STRQ;
        else lex_push(c);
        return 1'b0;
      end
      M_STRQ: begin
        if (c == CH_QUOTE) begin
          lex_push(c);
          scan_st = M_STR;
          return 1'b0;
        end
        emit_token(K_STRING);
        return 1'b1;
      end
      default: begin
        scan_st = M_IDLE;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void predict_byte(char_t c);
    if (scan_st == M_IDLE || feed_pending(c)) scan_fresh(c);
  endfunction

  // Sends one text byte as a request; called and returns just after a falling edge.
  task automatic send_byte(input char_t c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid     = 1'b0;
      in_text_byte = char_t'($urandom);
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = c;
    do @(posedge clk); while (in_stall);
    predict_byte(c);
    n_bytes++;
    if (!space_ch(c)) n_live_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(char_t'(s[i]));
  endtask

  // Compares one result field.
  task automatic check_field(input string name, input logic [LINE_W-1:0] want,
                             input logic [LINE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Each accepted result against the oldest expectation.
  task automatic check_beat();
    lexeme_beat_t want;
    if (lex_beats.size() == 0) begin
      $error("Result with no expectation: kind %0d byte %0d", out_token_kind,
             out_lexeme_byte);
      n_errors++;
    end else begin
      want = lex_beats.pop_front();
      check_field("token_kind", LINE_W'(want.kind), LINE_W'(out_token_kind));
      check_field("lexeme_byte", LINE_W'(want.lex), LINE_W'(out_lexeme_byte));
      check_field("byte_valid", LINE_W'(want.bvalid), LINE_W'(out_byte_valid));
      check_field("byte_index", LINE_W'(want.idx), LINE_W'(out_byte_index));
      check_field("last_of_token", LINE_W'(want.fin), LINE_W'(out_last_of_token));
      check_field("line_number", want.line, out_line_number);
      check_field("lexeme_overflow", LINE_W'(want.ovf), LINE_W'(out_lexeme_overflow));
      n_checked++;
      if (want.fin) n_tokens++;
      if (want.fin && want.ovf) n_overflows++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beat();
  end

  // Random text pieces.
  function automatic char_t rand_digit();
    return CH_ZERO + char_t'($urandom_range(0, 9));
  endfunction

  function automatic char_t rand_letter();
    if ($urandom_range(0, 1)) return CH_UP_A + char_t'($urandom_range(0, 25));
    return CH_LOW_A + char_t'($urandom_range(0, 25));
  endfunction

  function automatic char_t rand_space();
    if ($urandom_range(0, 5) == 0) return CH_SPACE;
    return CH_TAB + char_t'($urandom_range(0, 4));
  endfunction

  // Mostly short lexemes, now and then one near or past the buffer size.
  function automatic int rand_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(LEX_MAX - 8, LEX_MAX + 8);
    return $urandom_range(1, 5);
  endfunction

  task automatic send_digits(input int n);
    repeat (n) send_byte(rand_digit());
  endtask

  task automatic send_sign();
    case ($urandom_range(0, 2))
      1: send_byte(CH_MINUS);
      2: send_byte(CH_PLUS);
      default: ;
    endcase
  endtask

  // String body with doubled quotes, newlines and high bytes mixed in.
  task automatic send_string_body(input int n);
    char_t c;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: c = CH_QUOTE;
        1: c = CH_NL;
        2: c = char_t'($urandom_range(128, 255));
        default: c = char_t'($urandom_range(CH_SPACE, 126));
      endcase
      send_byte(c);
      if (c == CH_QUOTE) send_byte(c);
    end
  endtask

  // One random token, mostly well formed, followed now and then by whitespace.
  task automatic send_random_token();
    shape_t shape;
    shape = shape_t'($urandom_range(SH_INT, SH_NOISE));
    case (shape)
      SH_INT: begin
        send_sign();
        send_digits(rand_len());
      end
      SH_REAL: begin
        send_sign();
        send_digits(rand_len());
        send_byte(CH_DOT);
        send_digits($urandom_range(0, 4));
      end
      SH_DATE, SH_BROKEN_DATE: begin
        send_digits(rand_len());
        send_byte(CH_SLASH);
        send_digits($urandom_range(0, 3));
        if (shape == SH_DATE) begin
          send_byte(CH_SLASH);
          send_digits(rand_len());
        end
      end
      SH_IDENT: begin
        send_byte(rand_letter());
        repeat (rand_len() - 1) begin
          case ($urandom_range(0, 3))
            0: send_byte(rand_digit());
            1: send_byte(CH_UNDER);
            default: send_byte(rand_letter());
          endcase
        end
      end
      SH_NUMID: begin
        send_digits($urandom_range(1, 3));
        repeat (rand_len()) send_byte(rand_letter());
      end
      SH_STRING: begin
        send_byte(CH_QUOTE);
        send_string_body(rand_len() - 1);
        send_byte(CH_QUOTE);
      end
      SH_OPEN_STRING: begin
        send_byte(CH_QUOTE);
        send_string_body($urandom_range(0, 4));
        send_byte(CH_NUL);
      end
      SH_PUNCT: send_byte(char_t'(PUNCT[$urandom_range(0, PUNCT.len() - 1)]));
      SH_SPACE: send_byte(rand_space());
      SH_END:   send_byte(CH_NUL);
      default:  send_byte(char_t'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) send_byte(rand_space());
  endtask

  // Single-character tokens, lone signs and a newline ending a pending plus.
  task automatic test_punctuation();
    send_text("=:,?-+\n");
  endtask

  // Signed numbers, real, date, broken date, digits-then-letters and an underscore.
  task automatic test_numbers_idents();
    send_text("+12.5:-7,1/2/3 1/2 9ab_a_1?");
  endtask

  // Doubled quote, newline kept in a string, empty string, unterminated string.
  task automatic test_strings();
    send_text("\"a\"\"\nb\" \"\"");
    send_byte(CH_NUL);
    send_text("\"c");
    send_byte(CH_NUL);
  endtask

  // Control and high bytes, each sent back as a one-byte error token.
  task automatic test_stray_bytes();
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h7F);
  endtask

  // Random text under one mix of sender gaps and receiver stalls.
  task automatic test_random_text(input int src_pct, input int sink_pct, input int n_items);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    n_live_bytes   = 0;
    while (n_live_bytes < n_items) send_random_token();
  endtask

  // Newlines between tokens advance the line count; those inside a string do not.
  task automatic test_line_count();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (3) send_byte(CH_NL);
    send_text("z9 \"q\nr\" -5");
    send_byte(CH_NL);
    send_byte(CH_NUL);
  endtask

  initial begin
    scan_st        = M_IDLE;
    lex_len        = 0;
    line_cnt       = 1;
    lex_ovf        = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    n_bytes        = 0;
    n_live_bytes   = 0;
    n_checked      = 0;
    n_tokens       = 0;
    n_overflows    = 0;
    n_errors       = 0;
    cycle_cnt      = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = CH_NUL;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_punctuation();
    test_numbers_idents();
    test_strings();
    test_stray_bytes();
    test_random_text(0, 0, 45);
    test_random_text(61, 0, 45);
    test_random_text(0, 61, 45);
    test_random_text(30, 30, 45);
    test_line_count();
    in_valid = 1'b0;

    // Drain, then give the replay time to show anything unexpected.
    while (lex_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d text bytes, %0d lexeme bytes in %0d tokens (%0d overflowed).",
             n_bytes, n_checked, n_tokens, n_overflows);
    $display("Idle mixes: none, sender gaps, receiver stalls, both; line count ran to %0d.",
             line_cnt);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/tts_pkg.sv
src/tts_lexeme_ram.sv
src/tts_classify.sv
src/tts_replay.sv
src/text_token_scanner_top.sv
test/tb.sv
